// File: rtl/core/rss_pkg.sv
// rss_pkg: types, register indexes and reset constants of the rotary step selector.
// No dependencies; used by the channel interfaces and the top level.

package rss_pkg;

  // width of every configuration register
  localparam int unsigned CfgW = 20;
  // default width of the lockout and settle timers
  localparam int unsigned TimerWidthDef = 20;

  // register reset values
  localparam logic [CfgW-1:0] LockoutTicksRst = CfgW'(15000);
  localparam logic [CfgW-1:0] SettleTicksRst  = CfgW'(1000);
  localparam logic [CfgW-1:0] HoldoffTicksRst = CfgW'(150000);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LOCKOUT = 2'd0,
    REG_SETTLE  = 2'd1,
    REG_HOLDOFF = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_e;

  // step direction, also the step_event code of a result
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef logic [1:0] pos_t;
  typedef logic [3:0] led_t;

endpackage

// File: rtl/core/rss_stream_if.sv
// rss_in_if / rss_out_if: valid/ready channels of the rotary step selector.
// Depends on rss_pkg for the payload types.

interface rss_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic button;

  modport source (output valid, output pin_a, output pin_b, output button, input ready);
  modport sink   (input valid, input pin_a, input pin_b, input button, output ready);
endinterface

interface rss_out_if;
  logic          valid;
  logic          ready;
  rss_pkg::led_t led_pattern;
  logic          idle_indicator;
  rss_pkg::pos_t position;
  logic [1:0]    step_event;

  modport source (output valid, output led_pattern, output idle_indicator,
                  output position, output step_event, input ready);
  modport sink   (input valid, input led_pattern, input idle_indicator,
                  input position, input step_event, output ready);
endinterface

// File: rtl/core/rotary_step_selector.sv
// rotary_step_selector: rotary encoder step decoder with an enable button.
// Depends on rss_pkg and on the channel interfaces in rss_stream_if.sv.
//
// Usage:
//   in_i carries one pin sample per transfer: encoder channels A and B
//   (active low) and the enable button (1 = pressed). Each transfer is one
//   time tick for the lockout, settle and holdoff timers.
//   out_o carries exactly one result per input transfer, in order: the LED
//   pattern (one-hot position while enabled), the idle indicator, the
//   position and the step event of that tick.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write lockout_ticks (0), settle_ticks (1)
//   and button_holdoff_ticks (2); other indexes are dropped. Write only
//   while no transfer is in flight.
// Timing:
//   Two register stages: a sample is held in the input register, then the
//   decoder state and the result register update together when it moves
//   on. One transfer per cycle is sustained while out_o does not stall.
// Reset:
//   Asynchronous, active low. Position 0, disabled, lockout timer at zero
//   (the lockout runs from reset), both pins taken as high, registers at
//   their defaults (15000, 1000, 150000).
// Stall:
//   When out_o stalls, the result holds, the input register keeps one more
//   sample, and in_i.ready drops only once both are full.

module rotary_step_selector #(
  parameter int unsigned TIMER_WIDTH = rss_pkg::TimerWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [rss_pkg::CfgW-1:0] cfg_wdata_i,
  rss_in_if.sink                   in_i,
  rss_out_if.source                out_o
);

  localparam int unsigned CfgW = rss_pkg::CfgW;
  localparam int unsigned CmpW = (TIMER_WIDTH > CfgW) ? TIMER_WIDTH : CfgW;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  // configuration registers
  logic [CfgW-1:0] lockout_ticks_q, settle_ticks_q, holdoff_ticks_q;

  // input register
  logic s1_valid_q;
  logic s1_a_q, s1_b_q, s1_btn_q;

  // decoder state
  rss_pkg::pos_t          pos_q, pos_d;
  logic                   en_q, en_d;
  logic [TIMER_WIDTH-1:0] lock_cnt_q, lock_cnt_d;
  logic [TIMER_WIDTH-1:0] settle_cnt_q, settle_cnt_d;
  rss_pkg::dir_e          pend_q, pend_d;
  logic [1:0]             prev_pins_q;
  logic                   prev_btn_q, prev_btn_d;
  logic [CfgW-1:0]        hold_cnt_q, hold_cnt_d;

  // result register
  logic           out_valid_q;
  rss_pkg::led_t  led_q;
  logic           idle_q;
  rss_pkg::pos_t  opos_q;
  rss_pkg::dir_e  event_q;

  logic          advance;
  logic          in_ready;
  logic          fire;
  rss_pkg::dir_e event_d;
  rss_pkg::dir_e new_dir;
  logic          lock_open;
  logic          fall_a, fall_b;
  logic          up_ok, dn_ok, lvl_ok;
  logic [CmpW-1:0] need;
  logic [TIMER_WIDTH-1:0] settle_inc;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || advance;
  assign fire     = s1_valid_q && advance;
  assign in_i.ready = in_ready;

  // step decoding for the sample in the input register
  always_comb begin
    lock_open = CmpW'(lock_cnt_q) > CmpW'(lockout_ticks_q);
    fall_a = prev_pins_q[0] && !s1_a_q;
    fall_b = prev_pins_q[1] && !s1_b_q;
    up_ok  = !s1_a_q && s1_b_q;
    dn_ok  = !s1_b_q && s1_a_q;
    lvl_ok = (pend_q == rss_pkg::DIR_UP) ? up_ok : dn_ok;
    // a settle time of zero acts as one
    need = (settle_ticks_q == '0) ? CmpW'(1) : CmpW'(settle_ticks_q);
    settle_inc = (settle_cnt_q == TimerMax) ? settle_cnt_q : settle_cnt_q + 1'b1;

    event_d      = rss_pkg::DIR_NONE;
    pend_d       = pend_q;
    settle_cnt_d = settle_cnt_q;

    // confirm or drop a pending step
    if (pend_q != rss_pkg::DIR_NONE) begin
      if (lvl_ok) begin
        settle_cnt_d = settle_inc;
        if (CmpW'(settle_inc) >= need) begin
          event_d = pend_q;
          pend_d  = rss_pkg::DIR_NONE;
        end
      end else begin
        pend_d       = rss_pkg::DIR_NONE;
        settle_cnt_d = '0;
      end
    end

    // arm or take a new step on an edge whose confirming level is already there
    new_dir = rss_pkg::DIR_NONE;
    if (fall_a && up_ok) begin
      new_dir = rss_pkg::DIR_UP;
    end else if (fall_b && dn_ok) begin
      new_dir = rss_pkg::DIR_DOWN;
    end
    if (pend_d == rss_pkg::DIR_NONE && event_d == rss_pkg::DIR_NONE && lock_open &&
        new_dir != rss_pkg::DIR_NONE) begin
      settle_cnt_d = TIMER_WIDTH'(1);
      if (need == CmpW'(1)) begin
        event_d = new_dir;
      end else begin
        pend_d = new_dir;
      end
    end

    pos_d = pos_q;
    unique case (event_d)
      rss_pkg::DIR_UP:   pos_d = pos_q + 2'd1;
      rss_pkg::DIR_DOWN: pos_d = pos_q - 2'd1;
      default:           pos_d = pos_q;
    endcase

    if (event_d != rss_pkg::DIR_NONE) begin
      lock_cnt_d   = '0;
      settle_cnt_d = '0;
    end else begin
      lock_cnt_d = (lock_cnt_q == TimerMax) ? lock_cnt_q : lock_cnt_q + 1'b1;
    end

    // button toggle, ignored during holdoff
    en_d       = en_q;
    prev_btn_d = prev_btn_q;
    hold_cnt_d = hold_cnt_q;
    if (hold_cnt_q != '0) begin
      hold_cnt_d = hold_cnt_q - 1'b1;
    end else begin
      if (s1_btn_q && !prev_btn_q) begin
        en_d       = !en_q;
        hold_cnt_d = holdoff_ticks_q;
      end
      prev_btn_d = s1_btn_q;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_ticks_q <= rss_pkg::LockoutTicksRst;
      settle_ticks_q  <= rss_pkg::SettleTicksRst;
      holdoff_ticks_q <= rss_pkg::HoldoffTicksRst;
    end else if (cfg_we_i) begin
      unique case (rss_pkg::reg_idx_e'(cfg_idx_i))
        rss_pkg::REG_LOCKOUT: lockout_ticks_q <= cfg_wdata_i;
        rss_pkg::REG_SETTLE:  settle_ticks_q  <= cfg_wdata_i;
        rss_pkg::REG_HOLDOFF: holdoff_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register: load on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_a_q   <= in_i.pin_a;
      s1_b_q   <= in_i.pin_b;
      s1_btn_q <= in_i.button;
    end
  end

  // decoder state and result valid: advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      en_q         <= 1'b0;
      lock_cnt_q   <= '0;
      settle_cnt_q <= '0;
      pend_q       <= rss_pkg::DIR_NONE;
      prev_pins_q  <= 2'b11;
      prev_btn_q   <= 1'b0;
      hold_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        pos_q        <= pos_d;
        en_q         <= en_d;
        lock_cnt_q   <= lock_cnt_d;
        settle_cnt_q <= settle_cnt_d;
        pend_q       <= pend_d;
        prev_pins_q  <= {s1_b_q, s1_a_q};
        prev_btn_q   <= prev_btn_d;
        hold_cnt_q   <= hold_cnt_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      led_q   <= en_d ? (rss_pkg::led_t'(1) << pos_d) : '0;
      idle_q  <= !en_d;
      opos_q  <= pos_d;
      event_q <= event_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.led_pattern    = led_q;
  assign out_o.idle_indicator = idle_q;
  assign out_o.position       = opos_q;
  assign out_o.step_event     = event_q;

  // LED pattern agrees with the idle indicator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (idle_q ? (led_q == '0) : $onehot(led_q)))
    else $error("led pattern disagrees with enable");

  // a taken step restarts the lockout timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && event_d != rss_pkg::DIR_NONE) |=> (lock_cnt_q == '0))
    else $error("lockout not restarted after step");

  // position moves only with a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && event_d == rss_pkg::DIR_NONE) |=> (pos_q == $past(pos_q)))
    else $error("position moved without a step");

endmodule
